>>> hw/rtl/wrr_pkg.sv
// shared constants and codes of the window reorder receiver
package wrr_pkg;

   // default geometry of the reorder window and sequence space
   localparam int WINDOW_DEF       = 4;
   localparam int SEQ_SPACE_DEF    = 8;
   localparam int PAYLOAD_BITS_DEF = 32;

   // fixed field widths of the channels
   localparam int SEQ_NUM_W   = 3;
   localparam int PAYLOAD_W   = 32;
   localparam int ACK_W       = 4;
   localparam int SEQ_NUM_CNT = 1 << SEQ_NUM_W;

   // result kinds
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // ack number before anything was delivered in order
   localparam logic signed [ACK_W-1:0] ACK_NONE = -4'sd1;

endpackage

>>> hw/rtl/wrr_if.sv
// packet and result channel interfaces of the window reorder receiver
interface wrr_req_if;
   import wrr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SEQ_NUM_W-1:0] seq_num;
   logic                 checksum_ok;
   logic [PAYLOAD_W-1:0] payload_word;

   modport source (output valid, seq_num, checksum_ok, payload_word, input ready);
   modport sink   (input valid, seq_num, checksum_ok, payload_word, output ready);
endinterface

interface wrr_rsp_if;
   import wrr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [PAYLOAD_W-1:0]    delivered_payload;
   logic signed [ACK_W-1:0] ack_number;
   logic                    last_of_run;

   modport source (output valid, kind, delivered_payload, ack_number, last_of_run,
                   input ready);
   modport sink   (input valid, kind, delivered_payload, ack_number, last_of_run,
                   output ready);
endinterface

>>> hw/rtl/window_reorder_receiver.sv
// window reorder receiver: selective-repeat receive side with cumulative acks
//
// req_ch carries one packet per transfer: seq_num, checksum_ok, payload_word.
// rsp_ch carries results: deliveries (kind 0) in sequence order, then one ack
// (kind 1, last_of_run set) holding the last in-order sequence number, or -1
// before any. A corrupt packet gives no result at all.
// An in-order packet is delivered at once and then buffered successors are
// pulled from the reorder ram one by one; an in-window out-of-order packet is
// written to the ram, a duplicate or out-of-window packet is dropped.
// A corrupt packet returns from ST_EVAL to ST_IDLE; a packet with no delivery
// goes on to ST_ACK; an in-order packet goes through ST_CHK, and each buffered
// payload is read in ST_CHK (read issue) and ST_RD (registered read data).
// The block takes one packet at a time; ready is high while it waits for a
// packet, also while a finished result sits in the output register.
// Reset clears the window state (expected 0, ack -1, all slots empty) at
// once; the payload ram needs no clearing. A stalled rsp_ch holds the output
// register and the block waits with it, losing nothing.
module window_reorder_receiver #(
   parameter int WINDOW       = wrr_pkg::WINDOW_DEF,
   parameter int SEQ_SPACE    = wrr_pkg::SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = wrr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wrr_req_if.sink    req_ch,
   wrr_rsp_if.source  rsp_ch
);
   import wrr_pkg::*;

   localparam int SW    = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
   localparam int SEQ_W = $clog2(SEQ_SPACE);
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int DW    = $clog2(2 * SEQ_SPACE + WINDOW) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CHK,
      ST_RD,
      ST_ACK
   } state_type;

   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic                    ok_ff, ok_in;
   logic [SW-1:0]           pay_ff, pay_in;
   logic [SEQ_W-1:0]        exp_ff, exp_in;
   logic signed [ACK_W-1:0] last_ff, last_in;
   logic [WINDOW-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [PAYLOAD_W-1:0]    rsp_pay_ff, rsp_pay_in;
   logic signed [ACK_W-1:0] rsp_ack_ff, rsp_ack_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_we;
   logic                    ram_re;
   logic [SW-1:0]           ram_rdata;

   logic [IDX_W-1:0]        slot_of [SEQ_SPACE];
   logic [SEQ_W-1:0]        seq_red [SEQ_NUM_CNT];
   logic [IDX_W-1:0]        in_slot;
   logic [IDX_W-1:0]        exp_slot;
   logic [SEQ_W-1:0]        exp_next;
   logic [DW-1:0]           dsum;
   logic [DW-1:0]           mod_gap;
   logic                    in_order;
   logic                    in_win;
   logic                    accept;
   logic                    out_free;

   // constant tables: sequence number to slot, raw field to sequence space
   for (genvar g = 0; g < SEQ_SPACE; g++) begin : g_slot
      assign slot_of[g] = IDX_W'(g % WINDOW);
   end
   for (genvar g = 0; g < SEQ_NUM_CNT; g++) begin : g_red
      assign seq_red[g] = SEQ_W'(g % SEQ_SPACE);
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign in_slot  = slot_of[seq_ff];
   assign exp_slot = slot_of[exp_ff];
   assign exp_next = (exp_ff == SEQ_W'(SEQ_SPACE - 1)) ? '0 : exp_ff + SEQ_W'(1);

   // modular distance from the expected sequence number
   assign dsum     = DW'(seq_ff) + DW'(SEQ_SPACE) - DW'(exp_ff);
   assign mod_gap  = (dsum >= DW'(SEQ_SPACE)) ? dsum - DW'(SEQ_SPACE) : dsum;
   assign in_order = (mod_gap == '0);
   assign in_win   = (mod_gap < DW'(WINDOW));

   always_comb begin
      state_in     = state_ff;
      seq_in       = seq_ff;
      ok_in        = ok_ff;
      pay_in       = pay_ff;
      exp_in       = exp_ff;
      last_in      = last_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_in   = seq_red[req_ch.seq_num];
               ok_in    = req_ch.checksum_ok;
               pay_in   = req_ch.payload_word[SW-1:0];
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!ok_ff) begin
               state_in = ST_IDLE;
            end else if (in_order) begin
               if (out_free) begin
                  valid_in[in_slot] = 1'b0;
                  rsp_valid_in      = 1'b1;
                  rsp_kind_in       = KIND_DELIVER;
                  rsp_pay_in        = PAYLOAD_W'(pay_ff);
                  rsp_ack_in        = '0;
                  rsp_last_in       = 1'b0;
                  last_in           = ACK_W'(exp_ff);
                  exp_in            = exp_next;
                  cnt_in            = CNT_W'(1);
                  state_in          = ST_CHK;
               end
            end else begin
               // store in the window if it lies in range, unless the slot already holds this packet
               if (in_win && !valid_ff[in_slot]) begin
                  ram_we            = 1'b1;
                  valid_in[in_slot] = 1'b1;
               end
               state_in = ST_ACK;
            end
         end
         ST_CHK: begin
            if (cnt_ff < CNT_W'(WINDOW) && valid_ff[exp_slot]) begin
               ram_re             = 1'b1;
               valid_in[exp_slot] = 1'b0;
               state_in           = ST_RD;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_RD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DELIVER;
               rsp_pay_in   = PAYLOAD_W'(ram_rdata);
               rsp_ack_in   = '0;
               rsp_last_in  = 1'b0;
               last_in      = ACK_W'(exp_ff);
               exp_in       = exp_next;
               cnt_in       = cnt_ff + CNT_W'(1);
               state_in     = ST_CHK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_pay_in   = '0;
               rsp_ack_in   = last_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= '0;
         last_ff      <= ACK_NONE;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         last_ff      <= last_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff      <= seq_in;
      ok_ff       <= ok_in;
      pay_ff      <= pay_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_last_ff <= rsp_last_in;
   end

   // writes only happen for out-of-order packets, reads only in a later chain,
   // so the same slot is never written and read in overlapping cycles
   wrr_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (in_slot),
      .wr_data (pay_ff),
      .rd_en   (ram_re),
      .rd_addr (exp_slot),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready             = (state_ff == ST_IDLE);
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.kind              = rsp_kind_ff;
   assign rsp_ch.delivered_payload = rsp_pay_ff;
   assign rsp_ch.ack_number        = rsp_ack_ff;
   assign rsp_ch.last_of_run       = rsp_last_ff;

`ifndef SYNTH
   a_ack_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ACK |-> rsp_last_ff && rsp_pay_ff == '0)
      else $error("ack result without last_of_run or with payload");

   a_chain_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("delivery chain longer than the window");

   a_corrupt_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && !ok_ff |=> state_ff == ST_IDLE && valid_ff == $past(valid_ff))
      else $error("corrupt packet changed the window");

   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ram written and read in the same cycle");

   a_slot_freed: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> !valid_ff[$past(exp_slot)] && state_ff == ST_RD)
      else $error("buffered slot not freed on read");
`endif
endmodule

>>> hw/rtl/wrr_ram.sv
// generic single-port-write ram with registered read
module wrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
